/* rtl/core/ibcc_pkg.sv */
`timescale 1ns / 1ps

package ibcc_pkg;

  localparam int AXES    = 6;
  localparam int RAW_W   = 16;
  localparam int OUT_W   = 17;
  localparam int SUM_W   = 25;
  localparam int OFF_W   = 17;
  localparam int GRAV_W  = 15;
  localparam int CNT_W   = 9;
  localparam int QUOT_W  = 16;
  localparam int DIVX_W  = 26;  // 2*|sum| + N
  localparam int RECIP_K = 26;  // reciprocal scale, error of at most one count
  localparam int DIVD_W  = 10;  // 2*N

  localparam int CAL_SAMPLES_DEFAULT = 500;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam int IN_TDATA_W  = AXES * RAW_W;                     // 96
  localparam int OUT_TDATA_W = ((AXES * OUT_W + 7) / 8) * 8;     // 104

  // item classes, set by the front end
  localparam logic [1:0] KIND_CAL  = 2'd0;  // accumulate only
  localparam logic [1:0] KIND_LAST = 2'd1;  // accumulate, then build offsets
  localparam logic [1:0] KIND_CORR = 2'd2;  // correct and emit

  typedef logic [AXES-1:0][RAW_W-1:0] raw_vec_t;
  typedef logic [AXES-1:0][OUT_W-1:0] out_vec_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              clr;   // first sample of a calibration run
    logic [GRAV_W-1:0] grav;
    raw_vec_t          raw;
  } ibcc_entry_t;

endpackage

/* rtl/core/ibcc_front.sv */
`timescale 1ns / 1ps

module ibcc_front #(
  parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        restart,
  input  ibcc_pkg::raw_vec_t          raw,
  input  logic                        q_ready,
  input  logic                        cfg_valid,
  input  logic [ibcc_pkg::GRAV_W-1:0] cfg_data,
  output logic                        push,
  output ibcc_pkg::ibcc_entry_t       entry
);

  logic [ibcc_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic [ibcc_pkg::GRAV_W-1:0] grav_r;
  logic [ibcc_pkg::CNT_W-1:0]  cnt_base, cnt_inc;
  logic                        cal, last;

  assign push     = in_valid && q_ready;
  assign cnt_base = restart ? '0 : cnt_r;
  assign cnt_inc  = cnt_base + 1'b1;
  assign cal      = restart || !done_r;
  assign last     = cnt_inc >= ibcc_pkg::CNT_W'(CAL_SAMPLES);

  always_comb begin
    entry.raw  = raw;
    entry.grav = grav_r;
    entry.clr  = (cnt_base == '0);
    if (!cal) begin
      entry.kind = ibcc_pkg::KIND_CORR;
    end else if (last) begin
      entry.kind = ibcc_pkg::KIND_LAST;
    end else begin
      entry.kind = ibcc_pkg::KIND_CAL;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = done_r;
    if (push && cal) begin
      cnt_nxt  = cnt_inc;
      done_nxt = last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
      grav_r <= ibcc_pkg::GRAV_RESET;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
      if (cfg_valid) begin
        grav_r <= cfg_data;
      end
    end
  end

endmodule

/* rtl/core/ibcc_queue.sv */
`timescale 1ns / 1ps

module ibcc_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  ibcc_pkg::ibcc_entry_t wr_entry,
  output logic                  ready,
  input  logic                  pop,
  output logic                  head_valid,
  output ibcc_pkg::ibcc_entry_t head
);

  ibcc_pkg::ibcc_entry_t mem [ibcc_pkg::QUEUE_DEPTH];

  logic [ibcc_pkg::QUEUE_AW-1:0] wr_r, rd_r;
  logic [ibcc_pkg::QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign ready      = (cnt_r != ibcc_pkg::QUEUE_DEPTH[ibcc_pkg::QUEUE_AW:0]);
  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

endmodule

/* rtl/core/ibcc_back.sv */
`timescale 1ns / 1ps

module ibcc_back #(
  parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  ibcc_pkg::ibcc_entry_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ibcc_pkg::out_vec_t    out_data
);

  localparam int DIVX_W = ibcc_pkg::DIVX_W;
  localparam int QW     = ibcc_pkg::QUOT_W;
  localparam int K      = ibcc_pkg::RECIP_K;
  localparam logic [DIVX_W-1:0] DIVISOR = DIVX_W'(2 * CAL_SAMPLES);
  localparam logic [DIVX_W-1:0] RECIP   = DIVX_W'((64'd1 << K) / (2 * CAL_SAMPLES));

  // offset build sequencer phases
  localparam logic [1:0] PH_MUL = 2'd0;  // |sum| -> x, x * reciprocal
  localparam logic [1:0] PH_BCK = 2'd1;  // estimate * divisor
  localparam logic [1:0] PH_FIX = 2'd2;  // correct by one, sign, store

  logic signed [ibcc_pkg::SUM_W-1:0] sums_r [ibcc_pkg::AXES];
  logic signed [ibcc_pkg::OFF_W-1:0] offs_r [ibcc_pkg::AXES];
  logic [ibcc_pkg::GRAV_W-1:0]       grav_r;

  logic       busy_r, busy_nxt;
  logic [2:0] ax_r, ax_nxt;
  logic [1:0] ph_r, ph_nxt;

  logic [2*DIVX_W-1:0] prod_r;
  logic [DIVX_W-1:0]   x_r, qd_r;
  logic [QW-1:0]       qe_r;
  logic                neg_r;

  logic                out_valid_r, out_valid_nxt;
  ibcc_pkg::out_vec_t  out_data_r;

  logic                              take_corr;
  logic signed [ibcc_pkg::SUM_W-1:0] s_sel;
  logic [ibcc_pkg::SUM_W-1:0]        mag;
  logic [DIVX_W-1:0]                 x_val, rem;
  logic [QW-1:0]                     q_fix;
  logic signed [ibcc_pkg::OFF_W-1:0] q_s, off_val;

  // --- dispatch ---
  assign take_corr = (head.kind == ibcc_pkg::KIND_CORR);
  assign pop = head_valid && !busy_r && (!take_corr || !out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop && take_corr) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --- offset divider datapath ---
  assign s_sel = sums_r[ax_r];
  assign mag   = s_sel[ibcc_pkg::SUM_W-1] ? (~s_sel + 1'b1) : s_sel;
  assign x_val = {mag, 1'b0} + DIVX_W'(CAL_SAMPLES);
  assign rem   = x_r - qd_r;
  assign q_fix = qe_r + QW'(rem >= DIVISOR);
  assign q_s   = {1'b0, q_fix};

  always_comb begin
    off_val = neg_r ? -q_s : q_s;
    if (ax_r == 3'(ibcc_pkg::AXES - 1)) begin
      off_val = off_val - $signed({2'b00, grav_r});
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    ax_nxt   = ax_r;
    ph_nxt   = ph_r;
    if (busy_r) begin
      case (ph_r)
        PH_MUL: ph_nxt = PH_BCK;
        PH_BCK: ph_nxt = PH_FIX;
        PH_FIX: begin
          ph_nxt = PH_MUL;
          if (ax_r == 3'(ibcc_pkg::AXES - 1)) begin
            busy_nxt = 1'b0;
            ax_nxt   = '0;
          end else begin
            ax_nxt = ax_r + 1'b1;
          end
        end
        default: ph_nxt = PH_MUL;
      endcase
    end else if (pop && head.kind == ibcc_pkg::KIND_LAST) begin
      busy_nxt = 1'b1;
      ax_nxt   = '0;
      ph_nxt   = PH_MUL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      ax_r        <= '0;
      ph_r        <= PH_MUL;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      ax_r        <= ax_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !take_corr) begin
      for (int i = 0; i < ibcc_pkg::AXES; i++) begin
        sums_r[i] <= (head.clr ? '0 : sums_r[i])
                     + ibcc_pkg::SUM_W'($signed(head.raw[i]));
      end
      grav_r <= head.grav;
    end
    if (busy_r) begin
      case (ph_r)
        PH_MUL: begin
          neg_r  <= s_sel[ibcc_pkg::SUM_W-1];
          x_r    <= x_val;
          prod_r <= (2*DIVX_W)'(x_val) * (2*DIVX_W)'(RECIP);
        end
        PH_BCK: begin
          qe_r <= prod_r[K+QW-1:K];
          qd_r <= DIVX_W'(prod_r[K+QW-1:K]) * DIVX_W'(DIVISOR[ibcc_pkg::DIVD_W-1:0]);
        end
        PH_FIX: offs_r[ax_r] <= off_val;
        default: ;
      endcase
    end
    if (pop && take_corr) begin
      for (int i = 0; i < ibcc_pkg::AXES; i++) begin
        logic signed [ibcc_pkg::OFF_W:0] d;
        d = 18'($signed(head.raw[i])) - 18'(offs_r[i]);
        out_data_r[i] <= (d[ibcc_pkg::OFF_W:ibcc_pkg::OFF_W-1] == 2'b01)
                         ? {1'b0, {(ibcc_pkg::OUT_W-1){1'b1}}}
                         : d[ibcc_pkg::OUT_W-1:0];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // no item leaves the queue while offsets are being built
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !pop) else $error("pop during offset build");

  // offset build ends only after the last axis is stored
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> ($past(ax_r) == 3'(ibcc_pkg::AXES - 1)) && ($past(ph_r) == PH_FIX))
    else $error("offset build ended early");

  // a result only appears from a correction item
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pop) && ($past(head.kind) == ibcc_pkg::KIND_CORR))
    else $error("result without correction item");

  // axis counter stays in range
  a_ax_range: assert property (@(posedge clk) disable iff (!rst_n)
    ax_r <= 3'(ibcc_pkg::AXES - 1)) else $error("axis index out of range");

endmodule

/* rtl/core/imu_bias_calibrate_correct.sv */
`timescale 1ns / 1ps

// Six-axis IMU bias calibration and correction. After reset, or on a beat
// with restart_calibration set, the first CAL_SAMPLES beats are summed per
// axis and produce no output beat; the last of them triggers the offset
// build (sum / CAL_SAMPLES, rounded to nearest, ties away from zero, with
// gravity_reference taken off the z accel offset as written at the time
// that beat was accepted). Every later beat yields one output beat holding
// raw minus offset, saturated to 17 bits. Throughput is one beat per clock
// on correction traffic while out_tready stays high; each beat is held in
// the queue and then in the output register. The offset build runs one shared
// reciprocal-multiply divider axis by axis (multiply, back-multiply, fix);
// the 4-entry queue absorbs input during the build until full, then in_tready
// drops until the build ends. Config writes are always accepted (cfg_ready tied high).

module imu_bias_calibrate_correct #(
  parameter int CAL_SAMPLES = ibcc_pkg::CAL_SAMPLES_DEFAULT  // 1..511
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z (16 bits each)
  input  logic [ibcc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // restart_calibration
  input  logic                                 in_tuser,
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // corrected_gyro_x/y/z, corrected_accel_x/y/z (17 bits each), 2 zero pad
  output logic [ibcc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // gravity_reference write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ibcc_pkg::GRAV_W-1:0]          cfg_data
);

  logic                  q_ready, push, pop, head_valid;
  ibcc_pkg::ibcc_entry_t wr_entry, head;
  ibcc_pkg::raw_vec_t    raw;
  ibcc_pkg::out_vec_t    corr;

  assign raw       = in_tdata;
  assign in_tready = q_ready;
  assign cfg_ready = 1'b1;
  assign out_tdata = {(ibcc_pkg::OUT_TDATA_W - ibcc_pkg::AXES * ibcc_pkg::OUT_W)'(0), corr};

  // front end: count calibration beats, classify, hold gravity reference
  ibcc_front #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .restart   (in_tuser),
    .raw       (raw),
    .q_ready   (q_ready),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (wr_entry)
  );

  // decoupling queue between classification and execution
  ibcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_entry   (wr_entry),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // back end: accumulate, build offsets, correct and saturate
  ibcc_back #(
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (corr)
  );

endmodule
